/* hdl/iwaf_pkg.sv */
package iwaf_pkg;

	localparam int DENY_DEPTH_DEF  = 16;
	localparam int ALLOW_DEPTH_DEF = 16;

	// stored rule: wildcard bits on top, octets below
	localparam int RULE_W = 36;

	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_APPEND = 2'd1;
	localparam logic [1:0] MODE_CHECK  = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_UNUSABLE = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;

	localparam logic [3:0] ALL_WILD = 4'hf;

	// 127.*.*.* used when the allow list is empty
	localparam logic [RULE_W-1:0] IMPLICIT_RULE = {4'b0111, 8'd127, 24'hff_ffff};

	typedef struct packed {
		logic [1:0]  mode;
		logic        rule_is_deny;
		logic [31:0] rule_octets;
		logic [3:0]  rule_wild;
		logic [31:0] address;
	} req_t;

	typedef struct packed {
		logic       permitted;
		logic [1:0] status;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DENY,
		ST_ALLOW,
		ST_RESP
	} state_t;

	// wildcard bit k covers octet k, bit 3 is the first (top) octet
	function automatic logic rule_match(input logic [RULE_W-1:0] rule,
			input logic [31:0] addr);
		logic ok;
		ok = 1'b1;
		for (int k = 0; k < 4; k++) begin
			if (!rule[32+k] && (rule[8*k +: 8] != addr[8*k +: 8])) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage

/* hdl/ip_wildcard_access_filter.sv */
// channel  dir  handshake            payload
// req      in   req_valid/req_stall  req (iwaf_pkg::req_t)
// rsp      out  rsp_valid/rsp_stall  rsp (iwaf_pkg::rsp_t)
//
// Clear and append load the result register in the EXEC state.
// A check scans the deny store then the allow store, one rule per cycle
// through a single matcher; a hit ends the scan early. With an empty
// allow list the implicit 127.*.*.* rule is matched in its place.
// One item is in work at a time; req_stall is high until the result is
// loaded into the output register, as the block returns to idle.
// Reset clears counts and the unusable flag; rule stores are not cleared.
module ip_wildcard_access_filter #(
	parameter int DENY_DEPTH  = iwaf_pkg::DENY_DEPTH_DEF,
	parameter int ALLOW_DEPTH = iwaf_pkg::ALLOW_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  iwaf_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output iwaf_pkg::rsp_t  rsp
);

	localparam int DCW = $clog2(DENY_DEPTH + 1);
	localparam int ACW = $clog2(ALLOW_DEPTH + 1);
	localparam int IW  = (DCW > ACW) ? DCW : ACW;
	localparam int DAW = (DENY_DEPTH > 1) ? $clog2(DENY_DEPTH) : 1;
	localparam int AAW = (ALLOW_DEPTH > 1) ? $clog2(ALLOW_DEPTH) : 1;

	iwaf_pkg::state_t state_q, state_d;
	iwaf_pkg::req_t   item_q;
	iwaf_pkg::rsp_t   res_q, res_d, rsp_q;
	logic             rsp_valid_q;

	logic [DCW-1:0] deny_count_q;
	logic [ACW-1:0] allow_count_q;
	logic           all_denied_q;
	logic [IW-1:0]  idx_q;
	logic           vld_s1;

	logic [iwaf_pkg::RULE_W-1:0] deny_rdata, allow_rdata, match_rule, new_rule;
	logic match, deny_full, allow_full, deny_done, allow_done, issue;
	logic load_res, deny_we, allow_we, do_clear, set_all_denied, idx_clr, rsp_load;

	assign new_rule   = {item_q.rule_wild, item_q.rule_octets};
	assign deny_full  = deny_count_q >= DCW'(DENY_DEPTH);
	assign allow_full = allow_count_q >= ACW'(ALLOW_DEPTH);
	assign deny_done  = (idx_q == IW'(deny_count_q)) && !vld_s1;
	assign allow_done = (idx_q == IW'(allow_count_q)) && !vld_s1;

	// the one shared matcher
	always_comb begin
		if (state_q == iwaf_pkg::ST_ALLOW) begin
			match_rule = allow_rdata;
		end else if (deny_done) begin
			match_rule = iwaf_pkg::IMPLICIT_RULE;
		end else begin
			match_rule = deny_rdata;
		end
	end
	assign match = iwaf_pkg::rule_match(match_rule, item_q.address);

	assign rsp_load = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			iwaf_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = iwaf_pkg::ST_EXEC;
				end
			end
			iwaf_pkg::ST_EXEC: begin
				if (item_q.mode == iwaf_pkg::MODE_CHECK && !all_denied_q) begin
					state_d = iwaf_pkg::ST_DENY;
				end else begin
					state_d = iwaf_pkg::ST_RESP;
				end
			end
			iwaf_pkg::ST_DENY: begin
				if (vld_s1 && match) begin
					state_d = iwaf_pkg::ST_RESP;
				end else if (deny_done) begin
					state_d = (allow_count_q == '0) ? iwaf_pkg::ST_RESP : iwaf_pkg::ST_ALLOW;
				end
			end
			iwaf_pkg::ST_ALLOW: begin
				if ((vld_s1 && match) || allow_done) begin
					state_d = iwaf_pkg::ST_RESP;
				end
			end
			iwaf_pkg::ST_RESP: begin
				if (rsp_load) begin
					state_d = iwaf_pkg::ST_IDLE;
				end
			end
			default: state_d = iwaf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall      = 1'b1;
		res_d          = '{permitted: 1'b0, status: iwaf_pkg::STAT_OK};
		load_res       = 1'b0;
		deny_we        = 1'b0;
		allow_we       = 1'b0;
		do_clear       = 1'b0;
		set_all_denied = 1'b0;
		idx_clr        = 1'b0;
		issue          = 1'b0;
		unique case (state_q)
			iwaf_pkg::ST_IDLE: begin
				req_stall = 1'b0;
			end
			iwaf_pkg::ST_EXEC: begin
				load_res = 1'b1;
				idx_clr  = 1'b1;
				priority if (item_q.mode == iwaf_pkg::MODE_CLEAR) begin
					do_clear = 1'b1;
				end else if (item_q.mode == iwaf_pkg::MODE_APPEND) begin
					if (item_q.rule_is_deny) begin
						if (deny_full) begin
							res_d.status = iwaf_pkg::STAT_FULL;
						end else begin
							deny_we = 1'b1;
							if (item_q.rule_wild == iwaf_pkg::ALL_WILD) begin
								set_all_denied = 1'b1;
								res_d.status   = iwaf_pkg::STAT_UNUSABLE;
							end
						end
					end else if (allow_full) begin
						res_d.status = iwaf_pkg::STAT_FULL;
					end else begin
						allow_we = 1'b1;
					end
				end else if (item_q.mode == iwaf_pkg::MODE_CHECK && all_denied_q) begin
					res_d.status = iwaf_pkg::STAT_UNUSABLE;
				end else begin
					// check goes on to the scan; unused mode reports ok
					load_res = (item_q.mode != iwaf_pkg::MODE_CHECK);
				end
			end
			iwaf_pkg::ST_DENY: begin
				issue = idx_q < IW'(deny_count_q);
				if (vld_s1 && match) begin
					load_res = 1'b1;
				end else if (deny_done) begin
					idx_clr = 1'b1;
					if (allow_count_q == '0) begin
						load_res        = 1'b1;
						res_d.permitted = match;
					end
				end
			end
			iwaf_pkg::ST_ALLOW: begin
				issue = idx_q < IW'(allow_count_q);
				if (vld_s1 && match) begin
					load_res        = 1'b1;
					res_d.permitted = 1'b1;
				end else if (allow_done) begin
					load_res = 1'b1;
				end
			end
			iwaf_pkg::ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= iwaf_pkg::ST_IDLE;
			deny_count_q  <= '0;
			allow_count_q <= '0;
			all_denied_q  <= 1'b0;
			idx_q         <= '0;
			vld_s1        <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_clear) begin
				deny_count_q  <= '0;
				allow_count_q <= '0;
				all_denied_q  <= 1'b0;
			end
			if (deny_we) begin
				deny_count_q <= deny_count_q + DCW'(1);
			end
			if (allow_we) begin
				allow_count_q <= allow_count_q + ACW'(1);
			end
			if (set_all_denied) begin
				all_denied_q <= 1'b1;
			end
			if (idx_clr) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + IW'(1);
			end
			vld_s1 <= issue && !idx_clr;
			if (state_q == iwaf_pkg::ST_RESP && rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_q <= req;
		end
		if (load_res) begin
			res_q <= res_d;
		end
		if (state_q == iwaf_pkg::ST_RESP && rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	iwaf_ram #(
		.WIDTH (iwaf_pkg::RULE_W),
		.DEPTH (DENY_DEPTH)
	) u_deny_ram (
		.clk   (clk),
		.we    (deny_we),
		.waddr (deny_count_q[DAW-1:0]),
		.wdata (new_rule),
		.raddr (idx_q[DAW-1:0]),
		.rdata (deny_rdata)
	);

	iwaf_ram #(
		.WIDTH (iwaf_pkg::RULE_W),
		.DEPTH (ALLOW_DEPTH)
	) u_allow_ram (
		.clk   (clk),
		.we    (allow_we),
		.waddr (allow_count_q[AAW-1:0]),
		.wdata (new_rule),
		.raddr (idx_q[AAW-1:0]),
		.rdata (allow_rdata)
	);

endmodule

/* hdl/iwaf_ram.sv */
module iwaf_ram #(
	parameter int WIDTH = iwaf_pkg::RULE_W,
	parameter int DEPTH = iwaf_pkg::DENY_DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/iwaf_checker.sv */
module iwaf_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input iwaf_pkg::rsp_t rsp
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second transfer taken while busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == iwaf_pkg::STAT_OK ||
			rsp.status == iwaf_pkg::STAT_UNUSABLE || rsp.status == iwaf_pkg::STAT_FULL))
		else $error("bad status code");

	// only a clean check may permit
	a_permit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.permitted |-> rsp.status == iwaf_pkg::STAT_OK)
		else $error("permit with error status");

endmodule

bind ip_wildcard_access_filter iwaf_checker u_iwaf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
